// File: rtl/assert_macros.svh
// assertion macros shared by the timed release priority queue rtl
// depends on clk and arst_n being visible in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define TRPQ_ASSERT_HOLDS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TRPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/trpq_pkg.sv
// types and constants for the timed release priority queue
// no dependencies
package trpq_pkg;

	localparam int DEPTH      = 16;
	localparam int TIME_BITS  = 32;
	localparam int ID_BITS    = 16;
	localparam int COUNT_BITS = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_TICK   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t                  op;
		logic [TIME_BITS-1:0] ready_time;
		logic [ID_BITS-1:0]   item_id;
		logic [TIME_BITS-1:0] current_time;
	} in_item_t;

	typedef struct packed {
		logic                  released_valid;
		logic [ID_BITS-1:0]    released_id;
		logic                  last_of_run;
		status_t               status;
		logic [TIME_BITS-1:0]  next_due_time;
		logic                  head_changed;
		logic [COUNT_BITS-1:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] ready_time;
		logic [ID_BITS-1:0]   item_id;
	} entry_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic   insert;
		logic   pop;
		entry_t new_entry;
	} cell_cmd_t;

endpackage

// File: rtl/trpq_cell.sv
// one cell of the sorted entry chain: holds one entry, shifts with its neighbours
// depends on trpq_pkg
module trpq_cell (
	input  logic               clk,
	input  trpq_pkg::cell_cmd_t cmd,
	input  logic               occupied,
	input  logic               left_keep,
	input  trpq_pkg::entry_t   left_entry,
	input  trpq_pkg::entry_t   right_entry,
	output trpq_pkg::entry_t   entry,
	output logic               keep
);
	import trpq_pkg::*;

	entry_t entry_q;

	// equal times stay ahead of the new entry, giving fifo order on ties
	assign keep  = occupied && (entry_q.ready_time <= cmd.new_entry.ready_time);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		priority if (cmd.insert) begin
			if (!keep) begin
				entry_q <= left_keep ? cmd.new_entry : left_entry;
			end
		end else if (cmd.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// File: rtl/timed_release_priority_queue.sv
// top level of the timed release priority queue: control, result register, cell chain
// depends on trpq_pkg, trpq_cell and assert_macros.svh
//
// Entries (item id and ready time) sit in a chain of DEPTH cells kept sorted by
// ready time, soonest in cell 0, equal times in arrival order. An insert is
// broadcast to all cells: each cell either keeps its entry, takes the new one
// or takes its left neighbour's, so an insert completes at once whatever the
// position. A pop moves every entry one cell towards the head at once. Insert,
// remove, an empty tick and a tick with nothing due each give one result. A
// tick that releases n entries gives n results, one per cycle while the result
// register is free, each a pop at the head of the chain; no new transaction is
// taken until the final release is loaded into the result register. The result
// register separates the two sides, so a waiting result does not stop the next
// transaction from being taken once the register is free or being emptied.
// Op code 3 is ignored and answered with one status-only result. No clearing
// pass after reset: cells carry no valid state, occupancy decides which are live.
`include "assert_macros.svh"

module timed_release_priority_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  trpq_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output trpq_pkg::out_item_t result
);
	import trpq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_TICK = 2'b10
	} state_t;

	state_t                state_q, state_d;
	logic [COUNT_BITS-1:0] occ_q;
	logic [TIME_BITS-1:0]  now_q;
	logic                  result_valid_q;
	out_item_t             result_q, res;

	// cell chain wiring
	entry_t    cell_entry [DEPTH];
	logic      cell_keep  [DEPTH];
	cell_cmd_t cmd;

	logic                 slot_free, accept, in_tick, load_result;
	logic                 full, do_pop, pop_is_tick, pop_last;
	logic [TIME_BITS-1:0] old_head, pop_head, ins_head, now_sel;
	logic                 result_due_ok;

	// result slot free when empty or being taken this cycle
	assign slot_free  = !result_valid_q || result_ready;
	assign item_ready = (state_q == ST_IDLE) && slot_free;
	assign accept     = item_valid && item_ready;
	assign in_tick    = (state_q == ST_TICK) && slot_free;

	assign full     = (occ_q == COUNT_BITS'(DEPTH));
	assign old_head = (occ_q != '0) ? cell_entry[0].ready_time : '1;
	assign now_sel  = (state_q == ST_TICK) ? now_q : item.current_time;

	// head after a pop comes from cell 1
	assign pop_head = (occ_q > COUNT_BITS'(1)) ? cell_entry[1].ready_time : '1;
	// head after an insert
	assign ins_head = ((occ_q == '0) || (item.ready_time < cell_entry[0].ready_time))
		? item.ready_time : cell_entry[0].ready_time;

	always_comb begin
		do_pop      = 1'b0;
		pop_is_tick = 1'b0;
		if (in_tick) begin
			do_pop      = 1'b1;
			pop_is_tick = 1'b1;
		end else if (accept) begin
			unique case (item.op)
				OP_TICK: begin
					do_pop      = (occ_q != '0) &&
						(cell_entry[0].ready_time <= item.current_time);
					pop_is_tick = 1'b1;
				end
				OP_REMOVE: begin
					do_pop = (occ_q != '0);
				end
				OP_INSERT, OP_NONE: begin
					do_pop = 1'b0;
				end
				default: begin
					do_pop = 1'b0;
				end
			endcase
		end
	end

	// a release run ends when the next head is absent or not yet due
	assign pop_last = !pop_is_tick || (occ_q <= COUNT_BITS'(1)) ||
		(cell_entry[1].ready_time > now_sel);

	assign load_result = accept || in_tick;

	// result built from the state before the update
	always_comb begin
		res.released_valid = 1'b0;
		res.released_id    = '0;
		res.last_of_run    = 1'b1;
		res.status         = STAT_OK;
		res.next_due_time  = old_head;
		res.head_changed   = 1'b0;
		res.entry_count    = occ_q;
		if (do_pop) begin
			res.released_valid = 1'b1;
			res.released_id    = cell_entry[0].item_id;
			res.last_of_run    = pop_last;
			res.next_due_time  = pop_head;
			res.head_changed   = (pop_head != old_head);
			res.entry_count    = occ_q - COUNT_BITS'(1);
		end else if (accept) begin
			unique case (item.op)
				OP_INSERT: begin
					if (full) begin
						res.status = STAT_FULL;
					end else begin
						res.next_due_time = ins_head;
						res.head_changed  = (ins_head != old_head);
						res.entry_count   = occ_q + COUNT_BITS'(1);
					end
				end
				OP_TICK, OP_REMOVE: begin
					if (occ_q == '0) begin
						res.status = STAT_EMPTY;
					end
				end
				OP_NONE: begin
					res.status = STAT_OK;
				end
				default: begin
					res.status = STAT_OK;
				end
			endcase
		end
	end

	always_comb begin
		cmd.insert    = accept && (item.op == OP_INSERT) && !full;
		cmd.pop       = do_pop;
		cmd.new_entry = '{ready_time: item.ready_time, item_id: item.item_id};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (do_pop && !pop_last) begin
					state_d = ST_TICK;
				end
			end
			ST_TICK: begin
				if (in_tick && pop_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			occ_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.insert) begin
				occ_q <= occ_q + COUNT_BITS'(1);
			end else if (do_pop) begin
				occ_q <= occ_q - COUNT_BITS'(1);
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (load_result) begin
			result_q <= res;
		end
		if (accept) begin
			now_q <= item.current_time;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// sorted cell chain, head in cell 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic   occupied;
		logic   left_keep;
		entry_t left_entry;
		entry_t right_entry;

		assign occupied = (occ_q > COUNT_BITS'(i));

		if (i == 0) begin : g_head
			assign left_keep  = 1'b1;
			assign left_entry = '0;
		end else begin : g_body
			assign left_keep  = cell_keep[i-1];
			assign left_entry = cell_entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_entry = '0;
		end else begin : g_mid
			assign right_entry = cell_entry[i+1];
		end

		trpq_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occupied    (occupied),
			.left_keep   (left_keep),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (cell_entry[i]),
			.keep        (cell_keep[i])
		);
	end

	// an empty queue reports the never due time
	assign result_due_ok = (result_q.entry_count != '0) || (result_q.next_due_time == '1);

	// occupancy never passes the chain length
	`TRPQ_ASSERT_HOLDS(a_occ_bound, occ_q <= COUNT_BITS'(DEPTH), "occupancy beyond depth")
	// a release run only continues while entries remain
	`TRPQ_ASSERT_HOLDS(a_tick_nonempty, (state_q != ST_TICK) || (occ_q != '0), "empty run")
	// every pop removes exactly one entry
	`TRPQ_ASSERT_NEXT(a_pop_count, do_pop, (occ_q + COUNT_BITS'(1)) == $past(occ_q), "pop count")
	`TRPQ_ASSERT_HOLDS(a_empty_never, !result_valid_q || result_due_ok, "empty with a due time")

endmodule
